>>> src/dp11u_pkg.sv
// Package for the packed 11-bit depth unpacker.
// Holds the word types, register codes and fixed widths; depends on nothing.
package dp11u_pkg;

    // Fixed widths of the sample format and the frame counter.
    localparam int SAMPLE_BITS      = 11;
    localparam int ACC_BITS         = SAMPLE_BITS - 1;
    localparam int WIDE_BITS        = ACC_BITS + 8;
    localparam int HELD_BITS        = $clog2(SAMPLE_BITS);
    localparam int SUM_BITS         = $clog2(WIDE_BITS + 1);
    localparam int COUNT_BITS       = 20;
    localparam int FLAG_BYTE_POS    = 3;
    localparam int HEADER_BYTES_DEF = 12;

    // Reset values of the configuration registers.
    localparam logic [7:0]            START_FLAG_RST  = 8'h71;
    localparam logic [7:0]            MIDDLE_FLAG_RST = 8'h72;
    localparam logic [7:0]            END_FLAG_RST    = 8'h75;
    localparam logic [COUNT_BITS-1:0] PIXELS_RST      = 20'd307200;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_START_FLAG  = 2'd0;
    localparam cfg_index_t CFG_MIDDLE_FLAG = 2'd1;
    localparam cfg_index_t CFG_END_FLAG    = 2'd2;
    localparam cfg_index_t CFG_PIXELS      = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] depth_sample;
        logic                   sample_valid;
        logic [COUNT_BITS-1:0]  pixel_index;
        logic                   frame_end;
        logic                   frame_short;
    } out_word_t;

endpackage

>>> src/depth_packet_11bit_unpacker_unit.sv
// Top level of the packed 11-bit depth unpacker: input register, unpack logic,
// result register and configuration registers. Depends on dp11u_pkg.
//
//   Port group   Direction  Handshake               Word
//   in_*         in         in_valid / in_stall     in_word_t (byte, packet marks)
//   out_*        out        out_valid / out_stall   out_word_t (sample, frame end)
//   cfg_*        in         cfg_valid / cfg_ready   index and 20-bit data
//
// One byte is taken per cycle. A byte accepted at an edge is unpacked while it
// sits in the input register, and its result, if any, enters the result register
// once the stage moves. The rate is set by the single unpack stage, which updates
// the bit accumulator and pixel count once per cycle. While the result register
// is full and stalled the stage holds, and in_stall rises once the input register
// is full too. Reset empties both registers and clears all unpack state.
module depth_packet_11bit_unpacker_unit #(
    parameter int HEADER_BYTES = dp11u_pkg::HEADER_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dp11u_pkg::in_word_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dp11u_pkg::out_word_t                out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  dp11u_pkg::cfg_index_t               cfg_index,
    input  logic [dp11u_pkg::COUNT_BITS-1:0]    cfg_data
);
    import dp11u_pkg::*;

    localparam int HC_BITS = $clog2(HEADER_BYTES + 1);

    // Configuration registers.
    logic [7:0]            start_flag_reg;
    logic [7:0]            middle_flag_reg;
    logic [7:0]            end_flag_reg;
    logic [COUNT_BITS-1:0] pixels_reg;

    // Input register.
    logic     in_full_reg;
    in_word_t in_word_reg;

    // Unpack state.
    logic [HC_BITS-1:0]    header_count_reg, header_count_next;
    logic [7:0]            packet_flag_reg, packet_flag_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [HELD_BITS-1:0]  held_reg, held_next;
    logic [COUNT_BITS-1:0] pixel_count_reg, pixel_count_next;

    // Result register.
    logic      out_full_reg;
    out_word_t out_word_reg, out_word_next;
    logic      result_next;

    logic advance;

    // The stage moves whenever the result register is empty or being taken.
    assign advance   = !out_full_reg || !out_stall;
    assign in_stall  = in_full_reg && !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_full_reg;
    assign out_data  = out_word_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_flag_reg  <= START_FLAG_RST;
            middle_flag_reg <= MIDDLE_FLAG_RST;
            end_flag_reg    <= END_FLAG_RST;
            pixels_reg      <= PIXELS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_FLAG:  start_flag_reg  <= cfg_data[7:0];
                CFG_MIDDLE_FLAG: middle_flag_reg <= cfg_data[7:0];
                CFG_END_FLAG:    end_flag_reg    <= cfg_data[7:0];
                CFG_PIXELS:      pixels_reg      <= cfg_data;
                default:         pixels_reg      <= pixels_reg;
            endcase
        end
    end

    // Input register: loads a new word whenever it is empty or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_word_reg <= in_data;
        end
    end

    // Header tracking and MSB-first unpacking of one byte.
    always_comb
    begin
        logic [HC_BITS-1:0]   hc;
        logic                 known;
        logic [WIDE_BITS-1:0] wide;
        logic [SUM_BITS-1:0]  sum;
        logic [2:0]           rest;
        logic [SAMPLE_BITS-1:0] sample;
        logic                 sample_ok;
        logic                 fend;

        header_count_next = header_count_reg;
        packet_flag_next  = packet_flag_reg;
        acc_next          = acc_reg;
        held_next         = held_reg;
        pixel_count_next  = pixel_count_reg;
        sample_ok         = 1'b0;
        sample            = '0;
        wide              = {acc_reg, in_word_reg.data_byte};
        sum               = SUM_BITS'(held_reg) + SUM_BITS'(8);
        rest              = 3'(sum - SUM_BITS'(SAMPLE_BITS));
        known             = (packet_flag_reg == start_flag_reg)
                            || (packet_flag_reg == middle_flag_reg)
                            || (packet_flag_reg == end_flag_reg);

        hc = in_word_reg.first_of_packet ? '0 : header_count_reg;
        header_count_next = hc;

        if (hc < HC_BITS'(HEADER_BYTES))
        begin
            // Header byte; byte three carries the packet flag.
            if (hc == HC_BITS'(FLAG_BYTE_POS))
            begin
                packet_flag_next = in_word_reg.data_byte;
                if (in_word_reg.data_byte == start_flag_reg)
                begin
                    acc_next         = '0;
                    held_next        = '0;
                    pixel_count_next = '0;
                end
            end
            header_count_next = hc + HC_BITS'(1);
        end
        else if (known)
        begin
            // Payload byte of a frame packet.
            acc_next = wide[ACC_BITS-1:0];
            if (sum >= SUM_BITS'(SAMPLE_BITS))
            begin
                held_next = HELD_BITS'(rest);
                if (pixel_count_reg < pixels_reg)
                begin
                    sample_ok        = 1'b1;
                    sample           = SAMPLE_BITS'(wide >> rest);
                    pixel_count_next = pixel_count_reg + COUNT_BITS'(1);
                end
            end
            else
            begin
                held_next = HELD_BITS'(sum);
            end
        end

        fend = in_word_reg.last_of_packet
               && (header_count_next > HC_BITS'(FLAG_BYTE_POS))
               && (packet_flag_next == end_flag_reg);

        out_word_next.depth_sample = sample;
        out_word_next.sample_valid = sample_ok;
        out_word_next.pixel_index  = sample_ok ? pixel_count_reg : '0;
        out_word_next.frame_end    = fend;
        out_word_next.frame_short  = fend && (pixel_count_next < pixels_reg);
        result_next                = sample_ok || fend;
    end

    // Unpack state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= '0;
            packet_flag_reg  <= '0;
            acc_reg          <= '0;
            held_reg         <= '0;
            pixel_count_reg  <= '0;
            out_full_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= in_full_reg && result_next;
            if (in_full_reg)
            begin
                header_count_reg <= header_count_next;
                packet_flag_reg  <= packet_flag_next;
                acc_reg          <= acc_next;
                held_reg         <= held_next;
                pixel_count_reg  <= pixel_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_full_reg && result_next)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

>>> src/dp11u_checker.sv
// Port-level checks for the packed 11-bit depth unpacker, bound to its top level.
// Depends on dp11u_pkg and depth_packet_11bit_unpacker_unit.
module dp11u_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input dp11u_pkg::out_word_t             out_data
);
    import dp11u_pkg::*;

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Every result carries a sample or a frame end.
    a_out_useful: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.sample_valid || out_data.frame_end)
        else $error("empty result word");

    // A short frame is only reported with a frame end.
    a_short_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_short |-> out_data.frame_end)
        else $error("frame_short without frame_end");

    // Without a sample the sample fields read zero.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sample_valid
        |-> out_data.depth_sample == '0 && out_data.pixel_index == '0)
        else $error("sample fields set without a sample");

endmodule

bind depth_packet_11bit_unpacker_unit dp11u_checker u_dp11u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> verif/dp11u_sample_checker.sv
// Scoreboard for the packed 11-bit depth unpacker: watches the byte, result and
// register channels, predicts each result word and compares it field by field.
// Depends on dp11u_pkg for the word types, register codes and widths.
module dp11u_sample_checker #(
    parameter int HEADER_BYTES = dp11u_pkg::HEADER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  dp11u_pkg::in_word_t              in_data,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  dp11u_pkg::out_word_t             out_data,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  dp11u_pkg::cfg_index_t            cfg_index,
    input  logic [dp11u_pkg::COUNT_BITS-1:0] cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               samples_seen,
    output int                               frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import dp11u_pkg::*;

    // Register copies used by the prediction.
    logic [7:0]            start_flag_r  = START_FLAG_RST;
    logic [7:0]            middle_flag_r = MIDDLE_FLAG_RST;
    logic [7:0]            end_flag_r    = END_FLAG_RST;
    logic [COUNT_BITS-1:0] frame_pixels  = PIXELS_RST;

    // Unpack state as the block should hold it.
    logic [3:0]            hdr_seen  = '0;
    logic [7:0]            pkt_flag  = '0;
    logic [ACC_BITS-1:0]   acc_bits  = '0;
    logic [HELD_BITS-1:0]  held_bits = '0;
    logic [COUNT_BITS-1:0] pix_count = '0;

    out_word_t predicted_results[$];
    int        errors = 0;
    int        n_samples = 0;
    int        n_frames = 0;

    // Field list of one result word for the reports.
    function automatic string word_text(input out_word_t w);
        return $sformatf("sample=%h valid=%b index=%0d end=%b short=%b",
                         w.depth_sample, w.sample_valid, w.pixel_index,
                         w.frame_end, w.frame_short);
    endfunction

    // Advances the unpack state by one byte; returns 1 when a result word is due.
    function automatic bit unpack_byte(input in_word_t w, output out_word_t res);
        logic [WIDE_BITS-1:0] wide;
        logic [SUM_BITS-1:0]  sum;
        logic [SUM_BITS-1:0]  rest;
        res = '0;
        if (w.first_of_packet)
            hdr_seen = '0;
        if (hdr_seen < HEADER_BYTES) begin
            if (hdr_seen == FLAG_BYTE_POS) begin
                pkt_flag = w.data_byte;
                if (w.data_byte == start_flag_r) begin
                    acc_bits  = '0;
                    held_bits = '0;
                    pix_count = '0;
                end
            end
            hdr_seen = hdr_seen + 4'd1;
        end
        else if (pkt_flag == start_flag_r || pkt_flag == middle_flag_r ||
                 pkt_flag == end_flag_r) begin
            wide = {acc_bits, w.data_byte};
            sum  = SUM_BITS'(held_bits) + SUM_BITS'(8);
            if (sum >= SAMPLE_BITS) begin
                rest = sum - SUM_BITS'(SAMPLE_BITS);
                sum  = rest;
                // Samples past the end of the frame are dropped.
                if (pix_count < frame_pixels) begin
                    res.sample_valid = 1'b1;
                    res.depth_sample = SAMPLE_BITS'(wide >> rest);
                    res.pixel_index  = pix_count;
                    pix_count        = pix_count + 1'b1;
                end
            end
            acc_bits  = wide[ACC_BITS-1:0];
            held_bits = HELD_BITS'(sum);
        end
        // Frame end counts only once the flag byte of this packet has been seen.
        if (w.last_of_packet && hdr_seen > FLAG_BYTE_POS && pkt_flag == end_flag_r) begin
            res.frame_end   = 1'b1;
            res.frame_short = (pix_count < frame_pixels);
        end
        return res.sample_valid || res.frame_end;
    endfunction

    // Result words are checked before the byte of the same edge is predicted.
    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        out_word_t next_res;
        if (!rst_n) begin
            start_flag_r  = START_FLAG_RST;
            middle_flag_r = MIDDLE_FLAG_RST;
            end_flag_r    = END_FLAG_RST;
            frame_pixels  = PIXELS_RST;
            hdr_seen      = '0;
            pkt_flag      = '0;
            acc_bits      = '0;
            held_bits     = '0;
            pix_count     = '0;
            predicted_results.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (predicted_results.size() == 0) begin
                    if (errors < 10)
                        $display("[%0t] unexpected result word: %s",
                                 $realtime, word_text(out_data));
                    errors++;
                end
                else begin
                    want = predicted_results.pop_front();
                    if (out_data.depth_sample !== want.depth_sample ||
                        out_data.sample_valid !== want.sample_valid ||
                        out_data.pixel_index  !== want.pixel_index  ||
                        out_data.frame_end    !== want.frame_end    ||
                        out_data.frame_short  !== want.frame_short) begin
                        if (errors < 10)
                            $display("[%0t] result mismatch: expected %s, got %s",
                                     $realtime, word_text(want), word_text(out_data));
                        errors++;
                    end
                    if (want.sample_valid)
                        n_samples++;
                    if (want.frame_end)
                        n_frames++;
                end
            end
            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_FLAG:  start_flag_r  = cfg_data[7:0];
                    CFG_MIDDLE_FLAG: middle_flag_r = cfg_data[7:0];
                    CFG_END_FLAG:    end_flag_r    = cfg_data[7:0];
                    CFG_PIXELS:      frame_pixels  = cfg_data;
                    default: ;
                endcase
            end
            // Prediction for an accepted byte.
            if (in_valid && !in_stall) begin
                if (unpack_byte(in_data, next_res))
                    predicted_results.push_back(next_res);
            end
        end
        fail_count   <= errors;
        pending      <= predicted_results.size();
        samples_seen <= n_samples;
        frames_seen  <= n_frames;
    end

endmodule

>>> verif/depth_packet_11bit_unpacker_unit_tb.sv
// Testbench top for the packed 11-bit depth unpacker: clock, reset, packet and
// register stimulus, receiver stalls and the verdict.
// Depends on dp11u_pkg, depth_packet_11bit_unpacker_unit and dp11u_sample_checker.
module depth_packet_11bit_unpacker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dp11u_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 56;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_START_FLAG;
    logic [COUNT_BITS-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int samples_seen;
    int frames_seen;

    // Stimulus knobs shared with the stall process.
    int idle_pct    = 0;
    int stall_pct   = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int bytes_sent  = 0;

    // Current flags, kept so that packets can be built for the active setting.
    logic [7:0] cur_start  = START_FLAG_RST;
    logic [7:0] cur_middle = MIDDLE_FLAG_RST;
    logic [7:0] cur_end    = END_FLAG_RST;

    depth_packet_11bit_unpacker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dp11u_sample_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .samples_seen (samples_seen),
        .frames_seen  (frames_seen)
    );

    always #4 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is asked for.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_asked != holds_done) begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Offers one byte word and waits until it is taken.
    task automatic send_byte(input in_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends one packet: header with the flag at byte 3, then payload.
    // A fill below zero gives random payload bytes.
    task automatic send_packet(input logic [7:0] flag, input int hdr_len, input int payload_len,
                               input int fill, input bit mark_first, input bit noisy);
        in_word_t w;
        int       n;
        n = hdr_len + payload_len;
        for (int i = 0; i < n; i++) begin
            if (i == FLAG_BYTE_POS)
                w.data_byte = flag;
            else if (i >= hdr_len && fill >= 0)
                w.data_byte = 8'(fill);
            else
                w.data_byte = 8'($urandom);
            w.first_of_packet = mark_first && (i == 0);
            w.last_of_packet  = (i == n - 1);
            if (noisy) begin
                w.first_of_packet = ($urandom_range(0, 9) == 0);
                w.last_of_packet  = ($urandom_range(0, 5) == 0);
            end
            send_byte(w);
        end
    endtask

    // Lets the block run dry before a register write.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [COUNT_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A random frame: start packet, up to two middle packets and an end packet.
    task automatic send_frame();
        int mids;
        mids = $urandom_range(0, 2);
        send_packet(cur_start, HEADER_BYTES_DEF, $urandom_range(0, 20), -1, 1'b1, 1'b0);
        for (int m = 0; m < mids; m++)
            send_packet(cur_middle, HEADER_BYTES_DEF, $urandom_range(0, 20), -1, 1'b1, 1'b0);
        send_packet(cur_end, HEADER_BYTES_DEF, $urandom_range(0, 20), -1, 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] any_known_flag();
        case ($urandom_range(0, 2))
            0:       return cur_start;
            1:       return cur_middle;
            default: return cur_end;
        endcase
    endfunction

    initial begin
        logic [7:0]            f_start;
        logic [7:0]            f_middle;
        logic [7:0]            f_end;
        logic [COUNT_BITS-1:0] f_pixels;
        int                    pick;
        int                    target;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset register values.
        // A start packet right after reset, with no packet start mark.
        send_packet(START_FLAG_RST, HEADER_BYTES_DEF, 4, 8'hFF, 1'b0, 1'b0);
        // A middle packet of zero bytes, then one with an unknown flag.
        send_packet(MIDDLE_FLAG_RST, HEADER_BYTES_DEF, 3, 8'h00, 1'b1, 1'b0);
        send_packet(8'h00, HEADER_BYTES_DEF, 1, 8'hA5, 1'b1, 1'b0);
        // An end packet cut short just after the flag byte: a short frame.
        send_packet(END_FLAG_RST, FLAG_BYTE_POS + 1, 0, -1, 1'b1, 1'b0);
        // A packet that ends before its flag byte reports no frame end.
        send_packet(8'h00, FLAG_BYTE_POS, 0, -1, 1'b1, 1'b0);
        // An end packet without a start continues the current frame.
        send_packet(END_FLAG_RST, HEADER_BYTES_DEF, 3, -1, 1'b1, 1'b0);

        // Random part over several register settings and idle mixes.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin f_start = 8'h71; f_middle = 8'h72; f_end = 8'h75; f_pixels = PIXELS_RST; end
                1: begin f_start = 8'h00; f_middle = 8'h01; f_end = 8'hFF; f_pixels = 20'd1; end
                2: begin f_start = 8'hFF; f_middle = 8'hFE; f_end = 8'h00; f_pixels = 20'hFFFFF; end
                3: begin f_start = 8'h33; f_middle = 8'h33; f_end = 8'h33; f_pixels = 20'd20; end
                4: begin f_start = 8'h71; f_middle = 8'h72; f_end = 8'h75; f_pixels = 20'd0; end
                5: begin f_start = 8'hA5; f_middle = 8'h5A; f_end = 8'hC3; f_pixels = 20'd37; end
                6: begin f_start = 8'h10; f_middle = 8'h20; f_end = 8'h10; f_pixels = 20'd9; end
                default: begin f_start = 8'h71; f_middle = 8'h72; f_end = 8'h75; f_pixels = 20'd64; end
            endcase

            settle();
            write_reg(CFG_START_FLAG, COUNT_BITS'(f_start));
            write_reg(CFG_MIDDLE_FLAG, COUNT_BITS'(f_middle));
            write_reg(CFG_END_FLAG, COUNT_BITS'(f_end));
            write_reg(CFG_PIXELS, f_pixels);
            cur_start  = f_start;
            cur_middle = f_middle;
            cur_end    = f_end;

            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 64; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase

            // Hold the receiver off for a long stretch while bytes keep coming.
            if (phase == 0)
                holds_asked++;

            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    send_frame();
                else if (pick < 86)
                    send_packet(8'($urandom), HEADER_BYTES_DEF, $urandom_range(0, 6), -1,
                                1'b1, 1'b0);
                else if (pick < 93)
                    send_packet(any_known_flag(), $urandom_range(1, HEADER_BYTES_DEF - 1), 0, -1,
                                1'b1, 1'b0);
                else
                    send_packet(any_known_flag(), $urandom_range(2, 16), $urandom_range(0, 8), -1,
                                1'b1, 1'b1);
            end
        end

        settle();
        repeat (10) @(negedge clk);

        $display("Sent %0d bytes over %0d register settings and four idle mixes, one long hold-off.",
                 bytes_sent, PHASES);
        $display("Checked %0d depth samples and %0d frame ends.", samples_seen, frames_seen);
        if (fail_count == 0 && pending == 0)
            $display("depth_packet_11bit_unpacker_unit verification clean");
        else
            $display("depth_packet_11bit_unpacker_unit verification failed");
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("depth_packet_11bit_unpacker_unit verification failed");
        $finish;
    end

endmodule
